// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the per-key sequencer RTL of the key auto-repeat block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define KAR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define KAR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hw/rtl/kar_pkg.sv =====
// Types and constants of the key auto-repeat block.
`timescale 1ns / 1ps

package kar_pkg;

    localparam int KEY_W       = 12;
    localparam int CNT_W       = 16;
    localparam int STEP_W      = $clog2(CNT_W);
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD = 8'd1;

    localparam logic [CNT_W-1:0] DELAY_RESET  = 16'd30;
    localparam logic [CNT_W-1:0] PERIOD_RESET = 16'd6;

    typedef logic [KEY_W-1:0] t_key_mask;
    typedef logic [CNT_W-1:0] t_count;

    typedef struct packed {
        logic   start;
        t_count dividend;
        t_count divisor;
    } t_rem_req;

    typedef struct packed {
        logic done;
        logic zero;
    } t_rem_rsp;

    typedef struct packed {
        t_key_mask keystroke_mask;
        t_key_mask held_mask;
        logic      mask_changed;
    } t_result;

endpackage

// ===== hw/rtl/kar_key_if.sv =====
// Input channel: one frame tick with the sampled key states.
`timescale 1ns / 1ps

interface kar_key_if;
    import kar_pkg::*;

    logic      valid;
    logic      ready;
    t_key_mask keys_down;

    modport source (output valid, output keys_down, input ready);
    modport sink   (input valid, input keys_down, output ready);
endinterface

// ===== hw/rtl/kar_res_if.sv =====
// Output channel: keystroke, held and change masks of one tick.
`timescale 1ns / 1ps

interface kar_res_if;
    import kar_pkg::*;

    logic      valid;
    logic      ready;
    t_key_mask keystroke_mask;
    t_key_mask held_mask;
    logic      mask_changed;

    modport source (output valid, output keystroke_mask, output held_mask,
                    output mask_changed, input ready);
    modport sink   (input valid, input keystroke_mask, input held_mask,
                    input mask_changed, output ready);
endinterface

// ===== hw/rtl/kar_cfg_if.sv =====
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps

interface kar_cfg_if;
    import kar_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/kar_rem_unit.sv =====
// Bit-serial restoring remainder unit, one quotient bit per cycle.
`timescale 1ns / 1ps

module kar_rem_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kar_pkg::t_rem_req i_req,
    output kar_pkg::t_rem_rsp o_rsp
);
    import kar_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    t_count            r_rem;
    t_count            r_x;
    t_count            r_div;

    logic [CNT_W:0]    trial;
    logic              fits;
    t_count            n_rem;

    always_comb begin
        trial = {r_rem, r_x[CNT_W-1]};
        fits  = (trial >= {1'b0, r_div});
        n_rem = fits ? CNT_W'(trial - {1'b0, r_div}) : trial[CNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_rem  <= '0;
                r_x    <= i_req.dividend;
                r_div  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_x    <= {r_x[CNT_W-2:0], 1'b0};
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(CNT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.zero = (r_rem == '0);

endmodule

// ===== hw/rtl/kar_key_seq.sv =====
// Per-key sequencer: hold counters, keystroke decisions and tick masks.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kar_key_seq #(
    parameter int NUM_KEYS = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  kar_pkg::t_key_mask i_keys_down,
    input  kar_pkg::t_count    i_delay,
    input  kar_pkg::t_count    i_period,
    input  logic               i_res_free,
    output logic               o_idle,
    output logic               o_res_valid,
    output kar_pkg::t_result   o_res,
    output kar_pkg::t_rem_req  o_rem_req,
    input  kar_pkg::t_rem_rsp  i_rem_rsp
);
    import kar_pkg::*;

    // Keys at and above the mask width never see a press, so they hold no state.
    localparam int LP_ACT   = (NUM_KEYS < KEY_W) ? NUM_KEYS : KEY_W;
    localparam int LP_IDX_W = (LP_ACT > 1) ? $clog2(LP_ACT) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_KEY,
        S_REM,
        S_FIN
    } t_state;

    t_state              r_state;
    logic [LP_IDX_W-1:0] r_key;
    logic [LP_ACT-1:0]   r_down;
    logic [LP_ACT-1:0]   r_strokes;
    logic [LP_ACT-1:0]   r_held;
    logic [LP_ACT-1:0]   r_prev;
    t_count              r_cnt [LP_ACT];

    logic                key_down;
    t_count              n_cnt;
    logic                need_rem;
    logic                last_key;

    always_comb begin
        key_down = r_down[r_key];
        n_cnt    = key_down ? CNT_W'(r_cnt[r_key] + 1'b1) : '0;
        need_rem = key_down && (n_cnt >= i_delay);
        last_key = (r_key == LP_IDX_W'(LP_ACT - 1));
    end

    always_comb begin
        o_rem_req.start    = (r_state == S_KEY) && need_rem;
        o_rem_req.dividend = n_cnt - i_delay;
        o_rem_req.divisor  = (i_period == '0) ? CNT_W'(1) : i_period;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_key   <= '0;
            r_prev  <= '0;
            for (int k = 0; k < LP_ACT; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_down    <= i_keys_down[LP_ACT-1:0];
                        r_strokes <= '0;
                        r_held    <= '0;
                        r_key     <= '0;
                        r_state   <= S_KEY;
                    end
                end
                S_KEY: begin
                    r_cnt[r_key]  <= n_cnt;
                    r_held[r_key] <= (n_cnt != '0);
                    if (key_down && (n_cnt == CNT_W'(1))) begin
                        r_strokes[r_key] <= 1'b1;
                    end
                    if (need_rem) begin
                        r_state <= S_REM;
                    end else if (last_key) begin
                        r_state <= S_FIN;
                    end else begin
                        r_key <= r_key + 1'b1;
                    end
                end
                S_REM: begin
                    if (i_rem_rsp.done) begin
                        if (i_rem_rsp.zero) begin
                            r_strokes[r_key] <= 1'b1;
                        end
                        if (last_key) begin
                            r_state <= S_FIN;
                        end else begin
                            r_key   <= r_key + 1'b1;
                            r_state <= S_KEY;
                        end
                    end
                end
                S_FIN: begin
                    if (i_res_free) begin
                        r_prev  <= r_strokes;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_idle              = (r_state == S_IDLE);
    assign o_res_valid         = (r_state == S_FIN);
    assign o_res.keystroke_mask = KEY_W'(r_strokes);
    assign o_res.held_mask      = KEY_W'(r_held);
    assign o_res.mask_changed   = (r_strokes != r_prev);

    `KAR_ASSERT_IMP(a_key_in_range, i_clk, i_rst_n, 1'b1, r_key <= LP_IDX_W'(LP_ACT - 1))
    `KAR_ASSERT_IMP(a_done_in_rem, i_clk, i_rst_n, i_rem_rsp.done, r_state == S_REM)
    `KAR_ASSERT_NXT(a_start_to_rem, i_clk, i_rst_n, o_rem_req.start, r_state == S_REM)

endmodule

// ===== hw/rtl/key_auto_repeat_unit.sv =====
// Each tick steps through the keys in turn: a released key, or one whose count is
// below the delay, is settled in S_KEY; any other key waits in S_REM for a check
// in the shared bit-serial remainder unit. A new tick is taken only once the
// sequencer is idle again, after S_FIN has handed its result to the output register.
// Reset clears all hold counters, the previous keystroke mask and the output
// valid, and loads repeat_delay 30 and repeat_period 6.
`timescale 1ns / 1ps

module key_auto_repeat_unit #(
    parameter int NUM_KEYS = 12
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kar_cfg_if.sink   i_cfg,
    kar_key_if.sink   i_in,
    kar_res_if.source o_out
);
    import kar_pkg::*;

    t_count   r_delay;
    t_count   r_period;
    logic     r_out_valid;
    t_result  r_out;

    logic     seq_idle;
    logic     res_valid;
    logic     res_free;
    t_result  res;
    t_rem_req rem_req;
    t_rem_rsp rem_rsp;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay  <= DELAY_RESET;
            r_period <= PERIOD_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_REPEAT_DELAY:  r_delay  <= i_cfg.data;
                REG_REPEAT_PERIOD: r_period <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // The output register frees the sequencer as soon as its result is taken.
    assign res_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_free) begin
            r_out_valid <= res_valid;
            if (res_valid) begin
                r_out <= res;
            end
        end
    end

    assign i_in.ready           = seq_idle;
    assign o_out.valid          = r_out_valid;
    assign o_out.keystroke_mask = r_out.keystroke_mask;
    assign o_out.held_mask      = r_out.held_mask;
    assign o_out.mask_changed   = r_out.mask_changed;

    kar_key_seq #(
        .NUM_KEYS (NUM_KEYS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_in.valid && seq_idle),
        .i_keys_down (i_in.keys_down),
        .i_delay     (r_delay),
        .i_period    (r_period),
        .i_res_free  (res_free),
        .o_idle      (seq_idle),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_rem_req   (rem_req),
        .i_rem_rsp   (rem_rsp)
    );

    kar_rem_unit u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rem_req),
        .o_rsp   (rem_rsp)
    );

endmodule
